>>> design/srl_pkg.sv
// shared widths, register codes and item types for the setpoint ramp limiter
`default_nettype none

package srl_pkg;

  localparam int ValW    = 24;
  localparam int StepW   = 23;
  localparam int CfgIdxW = 1;

  localparam logic [StepW-1:0] StepRst = StepW'(256);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UP_STEP   = 1'b0,
    CFG_DOWN_STEP = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                   enable;
    logic signed [ValW-1:0] setpoint;
    logic signed [ValW-1:0] actual;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] ramped_value;
    logic                   going_up;
    logic                   going_down;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/srl_if.sv
// stream interfaces for the tick input and the ramp result
`default_nettype none

interface srl_in_if;
  logic                                valid;
  logic                                ready;
  logic                                enable;
  logic signed [srl_pkg::ValW-1:0]     setpoint;
  logic signed [srl_pkg::ValW-1:0]     actual;

  modport source (output valid, enable, setpoint, actual, input ready);
  modport sink   (input valid, enable, setpoint, actual, output ready);
endinterface

interface srl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [srl_pkg::ValW-1:0]     ramped_value;
  logic                                going_up;
  logic                                going_down;

  modport source (output valid, ramped_value, going_up, going_down, input ready);
  modport sink   (input valid, ramped_value, going_up, going_down, output ready);
endinterface

`default_nettype wire

>>> design/srl_in_reg.sv
// input register stage for control ticks
`default_nettype none

module srl_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  srl_in_if.sink                 in_ch,
  input  wire logic              adv,
  output logic                   s1_valid,
  output srl_pkg::in_item_t      s1_item
);

  assign in_ch.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.enable   <= in_ch.enable;
      s1_item.setpoint <= in_ch.setpoint;
      s1_item.actual   <= in_ch.actual;
    end
  end

endmodule

`default_nettype wire

>>> design/srl_ramp.sv
// ramp state, step registers and the per-tick update logic
`default_nettype none

module srl_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [srl_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [srl_pkg::StepW-1:0]   cfg_data,
  input  wire logic                        fire,
  input  wire srl_pkg::in_item_t           item,
  output srl_pkg::out_item_t               result
);

  localparam int ValW  = srl_pkg::ValW;
  localparam int StepW = srl_pkg::StepW;

  logic [StepW-1:0]       up_step;
  logic [StepW-1:0]       down_step;
  logic signed [ValW-1:0] output_value;
  logic signed [ValW-1:0] previous_setpoint;
  logic                   ramp_up_active;
  logic                   ramp_down_active;
  logic                   initialized;

  logic                   bypass;
  logic signed [ValW-1:0] start_value;
  logic                   start_up;
  logic                   start_down;
  logic signed [ValW:0]   up_sum;
  logic signed [ValW:0]   down_sum;
  logic signed [ValW-1:0] up_sat;
  logic signed [ValW-1:0] down_sat;
  logic signed [ValW-1:0] output_value_next;
  logic                   ramp_up_next;
  logic                   ramp_down_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_step   <= srl_pkg::StepRst;
      down_step <= srl_pkg::StepRst;
    end else if (cfg_we) begin
      unique case (srl_pkg::cfg_idx_t'(cfg_index))
        srl_pkg::CFG_UP_STEP:   up_step   <= cfg_data;
        srl_pkg::CFG_DOWN_STEP: down_step <= cfg_data;
      endcase
    end
  end

  assign bypass = !item.enable || !initialized;

  // setpoint change: start a ramp, or restart from actual if running the wrong way
  always_comb begin
    start_value = output_value;
    start_up    = ramp_up_active;
    start_down  = ramp_down_active;
    if (item.setpoint != previous_setpoint) begin
      if (!ramp_up_active && !ramp_down_active) begin
        if (item.setpoint > item.actual) begin
          start_up    = 1'b1;
          start_value = item.actual;
        end else if (item.setpoint < item.actual) begin
          start_down  = 1'b1;
          start_value = item.actual;
        end
      end else if (ramp_up_active) begin
        if (output_value > item.setpoint) begin
          start_up    = 1'b0;
          start_down  = 1'b1;
          start_value = item.actual;
        end
      end else if (item.setpoint > output_value) begin
        start_down  = 1'b0;
        start_up    = 1'b1;
        start_value = item.actual;
      end
    end
  end

  assign up_sum   = {start_value[ValW-1], start_value} + $signed({2'b00, up_step});
  assign down_sum = {start_value[ValW-1], start_value} - $signed({2'b00, down_step});

  // top two bits differ on overflow of the 24 bit range
  always_comb begin
    if (up_sum[ValW] != up_sum[ValW-1]) begin
      up_sat = {up_sum[ValW], {(ValW-1){~up_sum[ValW]}}};
    end else begin
      up_sat = up_sum[ValW-1:0];
    end
    if (down_sum[ValW] != down_sum[ValW-1]) begin
      down_sat = {down_sum[ValW], {(ValW-1){~down_sum[ValW]}}};
    end else begin
      down_sat = down_sum[ValW-1:0];
    end
  end

  always_comb begin
    output_value_next = start_value;
    ramp_up_next      = start_up;
    ramp_down_next    = start_down;
    if (bypass) begin
      output_value_next = item.setpoint;
      ramp_up_next      = 1'b0;
      ramp_down_next    = 1'b0;
    end else if (start_up) begin
      if (up_sat >= item.setpoint) begin
        output_value_next = item.setpoint;
        ramp_up_next      = 1'b0;
      end else begin
        output_value_next = up_sat;
      end
    end else if (start_down) begin
      if (down_sat <= item.setpoint) begin
        output_value_next = item.setpoint;
        ramp_down_next    = 1'b0;
      end else begin
        output_value_next = down_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_value      <= '0;
      previous_setpoint <= '0;
      ramp_up_active    <= 1'b0;
      ramp_down_active  <= 1'b0;
      initialized       <= 1'b0;
    end else if (fire) begin
      output_value      <= output_value_next;
      previous_setpoint <= item.setpoint;
      ramp_up_active    <= ramp_up_next;
      ramp_down_active  <= ramp_down_next;
      initialized       <= 1'b1;
    end
  end

  assign result.ramped_value = output_value_next;
  assign result.going_up     = ramp_up_next;
  assign result.going_down   = ramp_down_next;

endmodule

`default_nettype wire

>>> design/srl_out_reg.sv
// result register toward the output channel
`default_nettype none

module srl_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s1_valid,
  input  wire srl_pkg::out_item_t result,
  output logic                    adv,
  srl_out_if.source               out_ch
);

  assign adv = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_ch.ramped_value <= result.ramped_value;
      out_ch.going_up     <= result.going_up;
      out_ch.going_down   <= result.going_down;
    end
  end

endmodule

`default_nettype wire

>>> design/setpoint_step_ramp_limiter_top.sv
// setpoint ramp limiter: replaces setpoint jumps with rate-limited ramps
//
// in_ch carries one control tick per transfer: enable, setpoint and actual,
// all values signed Q16.8. out_ch returns exactly one result per tick:
// the ramped value and the flags of a running upward or downward ramp.
// cfg_we/cfg_index/cfg_data write up_step (index 0) and down_step (index 1),
// both unsigned Q15.8 per tick; write them only while no tick is in flight.
//
// a tick passes through one input register, then the ramp update logic
// feeding the result register that drives out_ch.
// throughput is one tick per clock while out_ch does not stall; the ramp
// state is written as a tick moves into the result register, so the next
// tick sees it at once.
// when out_ch stalls, the result register holds and the input register
// still takes one more tick; after that in_ch.ready drops until a transfer.
// reset clears the ramp state and sets both steps to 1.0; the first tick
// after reset passes its setpoint straight through.
`default_nettype none

module setpoint_step_ramp_limiter_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [srl_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [srl_pkg::StepW-1:0]   cfg_data,
  srl_in_if.sink                           in_ch,
  srl_out_if.source                        out_ch
);

  logic               adv;
  logic               s1_valid;
  srl_pkg::in_item_t  s1_item;
  srl_pkg::out_item_t result;

  srl_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  srl_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (s1_valid && adv),
    .item      (s1_item),
    .result    (result)
  );

  srl_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .result   (result),
    .adv      (adv),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> design/srl_checker.sv
// port-level checks for the setpoint ramp limiter, bound to the top level
`default_nettype none

module srl_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic signed [srl_pkg::ValW-1:0]  ramped_value,
  input wire logic                             going_up,
  input wire logic                             going_down
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ramped_value))
    else $error("stalled result changed");

  // the pipeline is empty right after reset
  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not ready after reset");

  // a ramp runs in one direction only
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(going_up && going_down))
    else $error("both ramp directions set");

  // the result register is full by the edge after an accepted tick
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after transfer");

endmodule

bind setpoint_step_ramp_limiter_top srl_checker u_srl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .ramped_value (out_ch.ramped_value),
  .going_up     (out_ch.going_up),
  .going_down   (out_ch.going_down)
);

`default_nettype wire

>>> dv/setpoint_step_ramp_limiter_top_tb.sv
// self-checking testbench for the setpoint ramp limiter: directed ticks, then random phases
`timescale 1ns / 100ps

function automatic logic signed [srl_pkg::ValW-1:0] clamp_q16_8(longint v);
  if (v > 64'sd8388607) return srl_pkg::ValW'(8388607);
  if (v < -64'sd8388608) return srl_pkg::ValW'(-8388608);
  return srl_pkg::ValW'(v);
endfunction

class ramp_scoreboard;
  logic signed [srl_pkg::ValW-1:0] out_value;
  logic signed [srl_pkg::ValW-1:0] last_setpoint;
  bit                              up_on;
  bit                              down_on;
  bit                              primed;
  logic [srl_pkg::StepW-1:0]       up_step;
  logic [srl_pkg::StepW-1:0]       down_step;
  srl_pkg::out_item_t              ramp_results_q[$];
  int                              mismatches;

  function new();
    out_value     = '0;
    last_setpoint = '0;
    up_on         = 1'b0;
    down_on       = 1'b0;
    primed        = 1'b0;
    up_step       = srl_pkg::StepRst;
    down_step     = srl_pkg::StepRst;
    mismatches    = 0;
  endfunction

  function void set_step(srl_pkg::cfg_idx_t idx, logic [srl_pkg::StepW-1:0] v);
    case (idx)
      srl_pkg::CFG_UP_STEP:   up_step = v;
      srl_pkg::CFG_DOWN_STEP: down_step = v;
      default: ;
    endcase
  endfunction

  function int pending();
    return ramp_results_q.size();
  endfunction

  // advance the ramp state by one accepted tick and queue the result it must give
  function void note_tick(srl_pkg::in_item_t t);
    srl_pkg::out_item_t r;
    if (!t.enable || !primed) begin
      up_on     = 1'b0;
      down_on   = 1'b0;
      primed    = 1'b1;
      out_value = t.setpoint;
    end else begin
      if (t.setpoint != last_setpoint) begin
        if (!up_on && !down_on) begin
          if (t.setpoint > t.actual) begin
            up_on     = 1'b1;
            out_value = t.actual;
          end else if (t.setpoint < t.actual) begin
            down_on   = 1'b1;
            out_value = t.actual;
          end
        end else if (up_on) begin
          // running upward but already past the new target
          if (out_value > t.setpoint) begin
            up_on     = 1'b0;
            down_on   = 1'b1;
            out_value = t.actual;
          end
        end else begin
          if (t.setpoint > out_value) begin
            down_on   = 1'b0;
            up_on     = 1'b1;
            out_value = t.actual;
          end
        end
      end
      if (up_on) begin
        out_value = clamp_q16_8(longint'(out_value) + longint'(up_step));
        if (out_value >= t.setpoint) begin
          out_value = t.setpoint;
          up_on     = 1'b0;
        end
      end else if (down_on) begin
        out_value = clamp_q16_8(longint'(out_value) - longint'(down_step));
        if (out_value <= t.setpoint) begin
          out_value = t.setpoint;
          down_on   = 1'b0;
        end
      end
    end
    last_setpoint  = t.setpoint;
    r.ramped_value = out_value;
    r.going_up     = up_on;
    r.going_down   = down_on;
    ramp_results_q.push_back(r);
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(srl_pkg::out_item_t got);
    srl_pkg::out_item_t want;
    if (ramp_results_q.size() == 0) begin
      report_mismatch($sformatf("result %0d with no tick pending", got.ramped_value));
    end else begin
      want = ramp_results_q.pop_front();
      if (got.ramped_value !== want.ramped_value)
        report_mismatch($sformatf("ramped_value %0d, want %0d",
                                  got.ramped_value, want.ramped_value));
      if (got.going_up !== want.going_up)
        report_mismatch($sformatf("going_up %b, want %b", got.going_up, want.going_up));
      if (got.going_down !== want.going_down)
        report_mismatch($sformatf("going_down %b, want %b", got.going_down, want.going_down));
    end
  endtask
endclass

module setpoint_step_ramp_limiter_top_tb;

  localparam int CycleLimit = 200000;
  localparam int DirN       = 20;

  // directed ticks: first-tick bypass, hold, ramp start, reversal both ways,
  // disable mid-ramp, equal setpoint and actual, saturation at both ends
  int dir_en  [DirN] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 1,
                         1, 1, 1, 1, 1, 1, 1, 0, 1, 0};
  int dir_sp  [DirN] = '{1000, 1000, 2000, 2000, 1500, 1100, 2900, 2900, -700, -700,
                         -600, -1000, 8388607, -8388608, 8388607, 8388607, -8388608,
                         0, 5592405, -5592406};
  int dir_act [DirN] = '{0, 0, 500, 123, 0, 3000, -50, 77, 5, 9,
                         -600, -800, 8388500, -8388500, -8388608, 0, 8388607,
                         0, -5592406, 5592405};

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we;
  logic [srl_pkg::CfgIdxW-1:0] cfg_index;
  logic [srl_pkg::StepW-1:0]   cfg_data;

  srl_in_if  in_ch();
  srl_out_if out_ch();

  ramp_scoreboard sb = new();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int cycle_count;
  logic signed [srl_pkg::ValW-1:0] cur_setpoint;

  setpoint_step_ramp_limiter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    srl_pkg::out_item_t got;
    srl_pkg::in_item_t  took;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.ramped_value = out_ch.ramped_value;
        got.going_up     = out_ch.going_up;
        got.going_down   = out_ch.going_down;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        took.enable   = in_ch.enable;
        took.setpoint = in_ch.setpoint;
        took.actual   = in_ch.actual;
        sb.note_tick(took);
      end
    end
  end

  // valid stays high across back-to-back transfers; a gap lowers it first
  task automatic send_tick(bit en, logic signed [srl_pkg::ValW-1:0] sp,
                           logic signed [srl_pkg::ValW-1:0] act);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.enable   <= en;
    in_ch.setpoint <= sp;
    in_ch.actual   <= act;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait for an edge first so the last transfer is already noted
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_steps(logic [srl_pkg::StepW-1:0] up,
                               logic [srl_pkg::StepW-1:0] down);
    cfg_we    <= 1'b1;
    cfg_index <= srl_pkg::CFG_UP_STEP;
    cfg_data  <= up;
    @(posedge clk);
    cfg_index <= srl_pkg::CFG_DOWN_STEP;
    cfg_data  <= down;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_step(srl_pkg::CFG_UP_STEP, up);
    sb.set_step(srl_pkg::CFG_DOWN_STEP, down);
  endtask

  // mostly held setpoints so ramps run out, with jumps scaled to the step size
  task automatic run_random(int n);
    int     k;
    int     pick;
    longint span;
    longint base;
    logic signed [srl_pkg::ValW-1:0] sp;
    logic signed [srl_pkg::ValW-1:0] act;
    span = (longint'(sb.up_step) + longint'(sb.down_step)) / 2 + 1;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      base = longint'(sb.out_value);
      if (pick < 6) begin
        sp  = srl_pkg::ValW'($urandom);
        act = srl_pkg::ValW'($urandom);
      end else begin
        if (pick < 30) sp = clamp_q16_8(base + (longint'($urandom_range(16)) - 8) * span);
        else sp = cur_setpoint;
        case ($urandom_range(9))
          0: act = sp;
          1: act = srl_pkg::ValW'($urandom);
          default: act = clamp_q16_8(base + (longint'($urandom_range(8)) - 4) * span
                                     + longint'($urandom_range(6)) - 3);
        endcase
      end
      cur_setpoint = sp;
      send_tick($urandom_range(99) >= 4, sp, act);
    end
  endtask

  task automatic run_phase(int sidle, int rstall, logic [srl_pkg::StepW-1:0] up,
                           logic [srl_pkg::StepW-1:0] down, int n, int hold);
    settle();
    program_steps(up, down);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    hold_request   = hold;
    run_random(n);
  endtask

  initial begin
    int k;
    in_ch.valid    = 1'b0;
    in_ch.enable   = 1'b0;
    in_ch.setpoint = '0;
    in_ch.actual   = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = srl_pkg::CFG_UP_STEP;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    cycle_count    = 0;
    cur_setpoint   = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < DirN; k++)
      send_tick(dir_en[k] != 0, srl_pkg::ValW'(dir_sp[k]), srl_pkg::ValW'(dir_act[k]));

    run_phase(0, 0, srl_pkg::StepRst, srl_pkg::StepRst, 300, 300);
    run_phase(72, 0, srl_pkg::StepW'(1), srl_pkg::StepW'(8388607), 280, 0);
    run_phase(0, 72, srl_pkg::StepW'(8388607), srl_pkg::StepW'(0), 280, 0);
    run_phase(32, 32, srl_pkg::StepW'($urandom_range(1, 2048)),
              srl_pkg::StepW'($urandom_range(1, 2048)), 280, 0);
    run_phase(0, 0, srl_pkg::StepW'(0), srl_pkg::StepW'(1), 280, 200);
    run_phase(32, 32, srl_pkg::StepW'($urandom), srl_pkg::StepW'($urandom), 280, 0);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
